[rtl/lmsnc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS noise canceller package
// Shared widths, reset values, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package lmsnc_pkg;

  localparam int unsigned TAPS_DEF = 32;
  localparam int unsigned SAMP_W   = 16;
  localparam int unsigned WGT_W    = 32;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned MA_W     = 32;
  localparam int unsigned MB_W     = 17;
  localparam int unsigned PROD_W   = MA_W + MB_W;

  localparam logic [STEP_W-1:0] STEP_RST = 16'd1311;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN,
    ST_SCALE,
    ST_SCALE_CAP,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_MAC,
    MUL_SCALE,
    MUL_UPD
  } mul_sel_e;

  typedef struct packed {
    logic     take;
    logic     acc_en;
    logic     ye_en;
    logic     se_en;
    logic     w_we;
    logic     out_load;
    mul_sel_e mul_sel;
  } ctrl_t;

endpackage

[rtl/lmsnc_taps.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS tap delay line
// Circular sample buffer with per-entry valid bits; read by tap age.
// ----------------------------------------------------------------------------
module lmsnc_taps
  import lmsnc_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic signed [SAMP_W-1:0] push_data_i,
  input  logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] rd_idx_i,
  output logic signed [SAMP_W-1:0] rd_data_o
);

  localparam int unsigned AW = (TAPS > 1) ? $clog2(TAPS) : 1;

  logic signed [SAMP_W-1:0] mem [TAPS];
  logic [TAPS-1:0]          vld_q;
  logic [AW-1:0]            wp_q, wp_d;
  logic [AW:0]              addr_wide;
  logic [AW-1:0]            rd_addr;
  logic signed [SAMP_W-1:0] rd_q;
  logic                     rv_q;

  assign wp_d = (wp_q == AW'(TAPS - 1)) ? '0 : wp_q + AW'(1);

  // newest sample sits at wp_q, older ones below it with wrap
  always_comb begin
    if (wp_q >= rd_idx_i) begin
      addr_wide = {1'b0, wp_q} - {1'b0, rd_idx_i};
    end else begin
      addr_wide = {1'b0, wp_q} + (AW + 1)'(TAPS) - {1'b0, rd_idx_i};
    end
  end
  assign rd_addr = addr_wide[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      vld_q <= '0;
    end else if (push_i) begin
      wp_q        <= wp_d;
      vld_q[wp_d] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wp_d] <= push_data_i;
    end
    rd_q <= mem[rd_addr];
    rv_q <= vld_q[rd_addr];
  end

  assign rd_data_o = rv_q ? rd_q : '0;

endmodule

[rtl/lmsnc_weights.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS coefficient store
// Weight memory, one read and one write port, per-entry valid bits.
// ----------------------------------------------------------------------------
module lmsnc_weights
  import lmsnc_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] rd_idx_i,
  input  logic                    wr_en_i,
  input  logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] wr_idx_i,
  input  logic signed [WGT_W-1:0] wr_data_i,
  output logic signed [WGT_W-1:0] rd_data_o
);

  logic signed [WGT_W-1:0] mem [TAPS];
  logic [TAPS-1:0]         vld_q;
  logic signed [WGT_W-1:0] rd_q;
  logic                    rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_q <= mem[rd_idx_i];
    rv_q <= vld_q[rd_idx_i];
  end

  assign rd_data_o = rv_q ? rd_q : '0;

endmodule

[rtl/lmsnc_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS shared arithmetic unit
// One registered multiplier, accumulator, output rounding, error
// saturation and the saturating coefficient update.
// ----------------------------------------------------------------------------
module lmsnc_alu
  import lmsnc_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic                     clk_i,
  input  ctrl_t                    ctrl_i,
  input  logic signed [SAMP_W-1:0] desired_i,
  input  logic [STEP_W-1:0]        step_i,
  input  logic signed [SAMP_W-1:0] tap_i,
  input  logic signed [WGT_W-1:0]  wgt_i,
  output logic signed [SAMP_W-1:0] y_o,
  output logic signed [SAMP_W-1:0] e_o,
  output logic signed [WGT_W-1:0]  wgt_new_o
);

  localparam int unsigned ACC_W = 48 + $clog2(TAPS);
  localparam int unsigned YS_W  = ACC_W - 30;
  localparam int unsigned INC_W = PROD_W - 16;
  localparam int unsigned NW_W  = INC_W + 1;

  localparam logic signed [YS_W-1:0]   Y_MAX = YS_W'(32767);
  localparam logic signed [YS_W-1:0]   Y_MIN = -YS_W'(32768);
  localparam logic signed [SAMP_W:0]   E_MAX = (SAMP_W + 1)'(32767);
  localparam logic signed [SAMP_W:0]   E_MIN = -(SAMP_W + 1)'(32768);
  localparam logic signed [NW_W-1:0]   W_MAX = NW_W'(64'sd2147483647);
  localparam logic signed [NW_W-1:0]   W_MIN = -NW_W'(64'sd2147483648);

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [YS_W-1:0]   y_sh;
  logic signed [SAMP_W-1:0] y_sat;
  logic signed [SAMP_W:0]   e_diff;
  logic signed [SAMP_W-1:0] e_sat;
  logic signed [SAMP_W-1:0] des_q, y_q, e_q;
  logic signed [MA_W-1:0]   se_q;
  logic signed [WGT_W-1:0]  w2_q;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [INC_W-1:0]  inc;
  logic signed [NW_W-1:0]   w_sum;

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_SCALE: begin
        mul_a = MA_W'(e_q);
        mul_b = signed'({1'b0, step_i});
      end
      MUL_UPD: begin
        mul_a = se_q;
        mul_b = MB_W'(tap_i);
      end
      default: begin
        mul_a = wgt_i;
        mul_b = MB_W'(tap_i);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    w2_q   <= wgt_i;
    if (ctrl_i.take) begin
      des_q <= desired_i;
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (ctrl_i.ye_en) begin
      y_q <= y_sat;
      e_q <= e_sat;
    end
    if (ctrl_i.se_en) begin
      se_q <= prod_q[MA_W-1:0];
    end
  end

  // output: round half up from Q3.45 to Q1.15, then clamp
  assign acc_rnd = acc_q + ACC_W'(64'sd536870912);
  assign y_sh    = YS_W'(acc_rnd >>> 30);

  always_comb begin
    if (y_sh > Y_MAX) begin
      y_sat = 16'sh7fff;
    end else if (y_sh < Y_MIN) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_sh[SAMP_W-1:0];
    end
  end

  assign e_diff = (SAMP_W + 1)'(des_q) - (SAMP_W + 1)'(y_sat);

  always_comb begin
    if (e_diff > E_MAX) begin
      e_sat = 16'sh7fff;
    end else if (e_diff < E_MIN) begin
      e_sat = -16'sh8000;
    end else begin
      e_sat = e_diff[SAMP_W-1:0];
    end
  end

  // update: round Q2.46 increment half up to Q2.30, clamp the new weight
  assign prod_rnd = prod_q + PROD_W'(32768);
  assign inc      = INC_W'(prod_rnd >>> 16);
  assign w_sum    = NW_W'(w2_q) + NW_W'(inc);

  always_comb begin
    if (w_sum > W_MAX) begin
      wgt_new_o = 32'sh7fffffff;
    end else if (w_sum < W_MIN) begin
      wgt_new_o = -32'sh80000000;
    end else begin
      wgt_new_o = w_sum[WGT_W-1:0];
    end
  end

  assign y_o = y_q;
  assign e_o = e_q;

endmodule

[rtl/lmsnc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS sequencer
// Runs the filter pass, the error and gain step, the update pass and the output handoff.
// ----------------------------------------------------------------------------
module lmsnc_ctrl
  import lmsnc_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  out_free_i,
  output ctrl_t ctrl_o,
  output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] rd_idx_o,
  output logic [((TAPS > 1) ? $clog2(TAPS) : 1)-1:0] wr_idx_o
);

  localparam int unsigned AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned CW = $clog2(TAPS + 2);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          issue;
  logic          v1_q, v2_q;
  logic [AW-1:0] idx1_q, idx2_q;
  logic          pass_end;

  assign issue    = ((state_q == ST_MAC) || (state_q == ST_UPD)) && (cnt_q < CW'(TAPS));
  assign pass_end = (cnt_q == CW'(TAPS + 1));
  assign rd_idx_o = cnt_q[AW-1:0];
  assign wr_idx_o = idx2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= cnt_q[AW-1:0];
    idx2_q <= idx1_q;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_stall_o = 1'b1;
    ctrl_o     = '{take: 1'b0, acc_en: 1'b0, ye_en: 1'b0, se_en: 1'b0,
                   w_we: 1'b0, out_load: 1'b0, mul_sel: MUL_MAC};
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cnt_d      = '0;
        if (in_valid_i) begin
          ctrl_o.take = 1'b1;
          state_d     = ST_MAC;
        end
      end
      ST_MAC: begin
        ctrl_o.acc_en = v2_q;
        if (pass_end) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_FIN: begin
        ctrl_o.ye_en = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        ctrl_o.mul_sel = MUL_SCALE;
        state_d        = ST_SCALE_CAP;
      end
      ST_SCALE_CAP: begin
        ctrl_o.se_en = 1'b1;
        cnt_d        = '0;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        ctrl_o.mul_sel = MUL_UPD;
        ctrl_o.w_we    = v2_q;
        if (pass_end) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/lms_adaptive_noise_canceller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LMS adaptive noise canceller
// Adaptive FIR of TAPS coefficients; returns noise estimate and cleaned signal.
// ----------------------------------------------------------------------------
// Each beat on the input carries a desired and a reference sample (Q1.15);
// one result beat follows with the filter output and the error, both
// saturated Q1.15. One multiplier does all the multiplies: a dot-product
// pass over the taps, one gain multiply, then an update pass that rewrites
// every coefficient. The input is stalled from acceptance until the result
// is loaded for output, so no new item is taken before then; a result
// waiting at the output does not hold up the next item until its update
// is done. Tap line and coefficients read as zero after reset through
// per-entry valid bits, with no clearing pass. step_size resets to 1311 and
// should be written only while the block is idle.
// ----------------------------------------------------------------------------
module lms_adaptive_noise_canceller
  import lmsnc_pkg::*;
#(
  parameter int unsigned TAPS = TAPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SAMP_W-1:0] desired_sample_i,
  input  logic signed [SAMP_W-1:0] reference_sample_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [SAMP_W-1:0] filter_out_o,
  output logic signed [SAMP_W-1:0] error_out_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [STEP_W-1:0]        cfg_data_i
);

  localparam int unsigned AW = (TAPS > 1) ? $clog2(TAPS) : 1;

  ctrl_t                    ctrl;
  logic [AW-1:0]            rd_idx, wr_idx;
  logic signed [SAMP_W-1:0] tap_rd;
  logic signed [WGT_W-1:0]  wgt_rd, wgt_new;
  logic signed [SAMP_W-1:0] y, e;
  logic [STEP_W-1:0]        step_q;
  logic                     out_valid_q;
  logic signed [SAMP_W-1:0] filter_q, error_q;
  logic                     out_free;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_data_i;
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      filter_q <= y;
      error_q  <= e;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filter_out_o = filter_q;
  assign error_out_o  = error_q;

  lmsnc_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .rd_idx_o   (rd_idx),
    .wr_idx_o   (wr_idx)
  );

  lmsnc_taps #(.TAPS(TAPS)) u_taps (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (ctrl.take),
    .push_data_i (reference_sample_i),
    .rd_idx_i    (rd_idx),
    .rd_data_o   (tap_rd)
  );

  lmsnc_weights #(.TAPS(TAPS)) u_weights (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .wr_en_i   (ctrl.w_we),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wgt_new),
    .rd_data_o (wgt_rd)
  );

  lmsnc_alu #(.TAPS(TAPS)) u_alu (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .desired_i (desired_sample_i),
    .step_i    (step_q),
    .tap_i     (tap_rd),
    .wgt_i     (wgt_rd),
    .y_o       (y),
    .e_o       (e),
    .wgt_new_o (wgt_new)
  );

endmodule
